FILE: hw/rtl/cptw_pkg.sv
// cptw_pkg: shared types, field widths and codes of the critical path time window unit
// no dependencies; imported by the controller, the datapath and the top level
package cptw_pkg;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 8;
    localparam int FT_W   = 16;
    localparam int LAG_W  = 16;
    localparam int ST_W   = 2;
    localparam int CFG_W  = 9;
    localparam int EDGE_W = 32;

    // edge word layout
    localparam int SRC_LSB = 0;
    localparam int TGT_LSB = 8;
    localparam int LAG_LSB = 16;

    localparam logic [CFG_W-1:0] JOBS_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        IN_LOAD = 2'd0,
        IN_EDGE = 2'd1,
        IN_RUN  = 2'd2,
        IN_READ = 2'd3
    } t_in_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_INFEAS = 2'd1,
        ST_CYCLE  = 2'd2,
        ST_OVF    = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        DP_IDLE     = 5'd0,
        DP_RD_A     = 5'd1,
        DP_RD_B     = 5'd2,
        DP_INIT_RD  = 5'd3,
        DP_INIT_WR  = 5'd4,
        DP_CNT_RD   = 5'd5,
        DP_CNT_CHK  = 5'd6,
        DP_CNT_WR   = 5'd7,
        DP_SEED_RD  = 5'd8,
        DP_SEED_WR  = 5'd9,
        DP_KHD_RD   = 5'd10,
        DP_KHD_V    = 5'd11,
        DP_KE_RD    = 5'd12,
        DP_KE_CHK   = 5'd13,
        DP_KE_WR    = 5'd14,
        DP_FWD_TRD  = 5'd15,
        DP_FWD_SRD  = 5'd16,
        DP_FWD_SV   = 5'd17,
        DP_FE_RD    = 5'd18,
        DP_FE_CHK   = 5'd19,
        DP_FE_WR    = 5'd20,
        DP_BWD_TRD  = 5'd21,
        DP_BWD_VRD  = 5'd22,
        DP_BWD_V    = 5'd23,
        DP_BE_RD    = 5'd24,
        DP_BE_CHK   = 5'd25,
        DP_BE_CALC  = 5'd26,
        DP_BWD_WB   = 5'd27,
        DP_DONE     = 5'd28
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   accept;
    } t_cmd;

    typedef struct packed {
        logic k_end;
        logic v_last;
        logic v_zero;
        logic q_empty;
        logic topo_full;
        logic hit_in;
        logic hit_src;
        logic out_free;
    } t_stat;

endpackage

FILE: hw/rtl/critical_path_time_windows_unit.sv
// critical_path_time_windows_unit: load and edge transactions are taken in the idle state, a read
// passes the RD_A and RD_B states and registers its result once the output is free; a run
// is paced by its scans over the edge memory in the count, order, forward and backward passes.
// one transaction is worked on at a time; synchronous active-low reset clears the edge
// count, overflow flag, run status and output valid, and sets jobs in use to 256
module critical_path_time_windows_unit import cptw_pkg::*; #(
    parameter int MAX_JOBS  = 256,
    parameter int MAX_EDGES = 1024,
    parameter int TIME_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_W-1:0]        i_cfg_wr_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [IDX_W-1:0]        i_job_index,
    input  logic [FT_W-1:0]         i_release_time,
    input  logic [FT_W-1:0]         i_deadline_time,
    input  logic [FT_W-1:0]         i_job_duration,
    input  logic [IDX_W-1:0]        i_edge_source,
    input  logic [IDX_W-1:0]        i_edge_target,
    input  logic signed [LAG_W-1:0] i_edge_lag,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ST_W-1:0]         o_status,
    output logic [FT_W-1:0]         o_earliest_start,
    output logic [FT_W-1:0]         o_latest_finish
);

    t_cmd  cmd;
    t_stat stat;

    cptw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    cptw_dp #(
        .MAX_JOBS  (MAX_JOBS),
        .MAX_EDGES (MAX_EDGES),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_operation      (i_operation),
        .i_job_index      (i_job_index),
        .i_release_time   (i_release_time),
        .i_deadline_time  (i_deadline_time),
        .i_job_duration   (i_job_duration),
        .i_edge_source    (i_edge_source),
        .i_edge_target    (i_edge_target),
        .i_edge_lag       (i_edge_lag),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_earliest_start (o_earliest_start),
        .o_latest_finish  (o_latest_finish)
    );

endmodule

FILE: hw/rtl/cptw_ram.sv
// cptw_ram: generic simple dual port ram, one write port, one registered read port
// no dependencies
module cptw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/cptw_ctrl.sv
// cptw_ctrl: sequencer of the unit, walks the run phases and the read and write transactions
// depends on cptw_pkg for command and status types
module cptw_ctrl import cptw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [OP_W-1:0]   i_operation,
    input  t_stat             i_stat,
    output logic              o_in_ready,
    output t_cmd              o_cmd
);

    typedef enum logic [28:0] {
        S_IDLE     = (29'd1 << 0),
        S_RD_A     = (29'd1 << 1),
        S_RD_B     = (29'd1 << 2),
        S_INIT_RD  = (29'd1 << 3),
        S_INIT_WR  = (29'd1 << 4),
        S_CNT_RD   = (29'd1 << 5),
        S_CNT_CHK  = (29'd1 << 6),
        S_CNT_WR   = (29'd1 << 7),
        S_SEED_RD  = (29'd1 << 8),
        S_SEED_WR  = (29'd1 << 9),
        S_KHD_RD   = (29'd1 << 10),
        S_KHD_V    = (29'd1 << 11),
        S_KE_RD    = (29'd1 << 12),
        S_KE_CHK   = (29'd1 << 13),
        S_KE_WR    = (29'd1 << 14),
        S_FWD_TRD  = (29'd1 << 15),
        S_FWD_SRD  = (29'd1 << 16),
        S_FWD_SV   = (29'd1 << 17),
        S_FE_RD    = (29'd1 << 18),
        S_FE_CHK   = (29'd1 << 19),
        S_FE_WR    = (29'd1 << 20),
        S_BWD_TRD  = (29'd1 << 21),
        S_BWD_VRD  = (29'd1 << 22),
        S_BWD_V    = (29'd1 << 23),
        S_BE_RD    = (29'd1 << 24),
        S_BE_CHK   = (29'd1 << 25),
        S_BE_CALC  = (29'd1 << 26),
        S_BWD_WB   = (29'd1 << 27),
        S_DONE     = (29'd1 << 28)
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (t_in_op'(i_operation) == IN_RUN)) n_state = S_INIT_RD;
                else if (accept && (t_in_op'(i_operation) == IN_READ)) n_state = S_RD_A;
            end
            S_RD_A:    n_state = S_RD_B;
            S_RD_B:    if (i_stat.out_free) n_state = S_IDLE;
            S_INIT_RD: n_state = S_INIT_WR;
            S_INIT_WR: n_state = i_stat.v_last ? S_CNT_RD : S_INIT_RD;
            S_CNT_RD:  n_state = i_stat.k_end ? S_SEED_RD : S_CNT_CHK;
            S_CNT_CHK: n_state = i_stat.hit_in ? S_CNT_WR : S_CNT_RD;
            S_CNT_WR:  n_state = S_CNT_RD;
            S_SEED_RD: n_state = S_SEED_WR;
            S_SEED_WR: n_state = i_stat.v_last ? S_KHD_RD : S_SEED_RD;
            S_KHD_RD: begin
                if (!i_stat.q_empty) n_state = S_KHD_V;
                else if (i_stat.topo_full) n_state = S_FWD_TRD;
                else n_state = S_DONE;
            end
            S_KHD_V:   n_state = S_KE_RD;
            S_KE_RD:   n_state = i_stat.k_end ? S_KHD_RD : S_KE_CHK;
            S_KE_CHK:  n_state = i_stat.hit_src ? S_KE_WR : S_KE_RD;
            S_KE_WR:   n_state = S_KE_RD;
            S_FWD_TRD: n_state = S_FWD_SRD;
            S_FWD_SRD: n_state = S_FWD_SV;
            S_FWD_SV:  n_state = S_FE_RD;
            S_FE_RD: begin
                if (!i_stat.k_end) n_state = S_FE_CHK;
                else if (i_stat.v_last) n_state = S_BWD_TRD;
                else n_state = S_FWD_TRD;
            end
            S_FE_CHK:  n_state = i_stat.hit_src ? S_FE_WR : S_FE_RD;
            S_FE_WR:   n_state = S_FE_RD;
            S_BWD_TRD: n_state = S_BWD_VRD;
            S_BWD_VRD: n_state = S_BWD_V;
            S_BWD_V:   n_state = S_BE_RD;
            S_BE_RD:   n_state = i_stat.k_end ? S_BWD_WB : S_BE_CHK;
            S_BE_CHK:  n_state = i_stat.hit_src ? S_BE_CALC : S_BE_RD;
            S_BE_CALC: n_state = S_BE_RD;
            S_BWD_WB:  n_state = i_stat.v_zero ? S_DONE : S_BWD_TRD;
            S_DONE:    if (i_stat.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.accept = accept;
        unique case (r_state)
            S_IDLE:    o_cmd.op = DP_IDLE;
            S_RD_A:    o_cmd.op = DP_RD_A;
            S_RD_B:    o_cmd.op = DP_RD_B;
            S_INIT_RD: o_cmd.op = DP_INIT_RD;
            S_INIT_WR: o_cmd.op = DP_INIT_WR;
            S_CNT_RD:  o_cmd.op = DP_CNT_RD;
            S_CNT_CHK: o_cmd.op = DP_CNT_CHK;
            S_CNT_WR:  o_cmd.op = DP_CNT_WR;
            S_SEED_RD: o_cmd.op = DP_SEED_RD;
            S_SEED_WR: o_cmd.op = DP_SEED_WR;
            S_KHD_RD:  o_cmd.op = DP_KHD_RD;
            S_KHD_V:   o_cmd.op = DP_KHD_V;
            S_KE_RD:   o_cmd.op = DP_KE_RD;
            S_KE_CHK:  o_cmd.op = DP_KE_CHK;
            S_KE_WR:   o_cmd.op = DP_KE_WR;
            S_FWD_TRD: o_cmd.op = DP_FWD_TRD;
            S_FWD_SRD: o_cmd.op = DP_FWD_SRD;
            S_FWD_SV:  o_cmd.op = DP_FWD_SV;
            S_FE_RD:   o_cmd.op = DP_FE_RD;
            S_FE_CHK:  o_cmd.op = DP_FE_CHK;
            S_FE_WR:   o_cmd.op = DP_FE_WR;
            S_BWD_TRD: o_cmd.op = DP_BWD_TRD;
            S_BWD_VRD: o_cmd.op = DP_BWD_VRD;
            S_BWD_V:   o_cmd.op = DP_BWD_V;
            S_BE_RD:   o_cmd.op = DP_BE_RD;
            S_BE_CHK:  o_cmd.op = DP_BE_CHK;
            S_BE_CALC: o_cmd.op = DP_BE_CALC;
            S_BWD_WB:  o_cmd.op = DP_BWD_WB;
            S_DONE:    o_cmd.op = DP_DONE;
            default:   o_cmd.op = DP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/cptw_dp.sv
// cptw_dp: datapath with job, time, pending count, order and edge memories,
// scan counters and the start and finish arithmetic; depends on cptw_pkg and cptw_ram
module cptw_dp import cptw_pkg::*; #(
    parameter int MAX_JOBS  = 256,
    parameter int MAX_EDGES = 1024,
    parameter int TIME_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_W-1:0]     i_cfg_wr_data,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [IDX_W-1:0]     i_job_index,
    input  logic [FT_W-1:0]      i_release_time,
    input  logic [FT_W-1:0]      i_deadline_time,
    input  logic [FT_W-1:0]      i_job_duration,
    input  logic [IDX_W-1:0]     i_edge_source,
    input  logic [IDX_W-1:0]     i_edge_target,
    input  logic signed [LAG_W-1:0] i_edge_lag,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [ST_W-1:0]      o_status,
    output logic [FT_W-1:0]      o_earliest_start,
    output logic [FT_W-1:0]      o_latest_finish
);
    localparam int JB    = $clog2(MAX_JOBS);
    localparam int EB    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W = EB + 1;
    localparam int JV_W  = JB + 1;
    localparam int IW    = (JV_W > CFG_W) ? JV_W : CFG_W;
    localparam int TB    = TIME_BITS;
    localparam int XW    = (TB > FT_W) ? TB : FT_W;
    localparam int CW    = XW + 3;
    localparam int JOB_W = 3 * TB;
    localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};

    function automatic logic [TB-1:0] sat_in(input logic [FT_W-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        if (x > XW'(TIME_MAX)) return TIME_MAX;
        return TB'(x);
    endfunction

    function automatic logic [TB-1:0] sat_c(input logic signed [CW-1:0] c);
        if (c < 0) return '0;
        if (c > $signed(CW'(TIME_MAX))) return TIME_MAX;
        return TB'(c);
    endfunction

    // memory ports
    logic             job_we, start_we, fin_we, pend_we, topo_we, edge_we;
    logic [JB-1:0]    job_wa, start_wa, fin_wa, pend_wa, topo_wa;
    logic [JB-1:0]    job_ra, start_ra, fin_ra, pend_ra, topo_ra;
    logic [EB-1:0]    edge_wa, edge_ra;
    logic [JOB_W-1:0] job_wd, job_q;
    logic [TB-1:0]    start_wd, start_q, fin_wd, fin_q;
    logic [CNT_W-1:0] pend_wd, pend_q;
    logic [JB-1:0]    topo_wd, topo_q;
    logic [EDGE_W-1:0] edge_wd, edge_q;

    // control registers
    logic [CNT_W-1:0] r_edge_total;
    logic             r_ovf;
    logic [ST_W-1:0]  r_run_status;
    logic [CFG_W-1:0] r_jobs;
    logic             r_ov;

    // run registers
    logic [JV_W-1:0]  r_n, r_v, r_head, r_tail;
    logic [CNT_W-1:0] r_k;
    logic [JB-1:0]    r_cur, r_tgt, r_idx;
    logic             r_oob;
    logic [TB-1:0]    r_val, r_dur, r_cs;
    logic signed [LAG_W-1:0] r_lag;
    logic             r_infeas;
    logic [ST_W-1:0]  r_out_status;
    logic [FT_W-1:0]  r_out_es, r_out_lf;

    logic [IW-1:0]    e_src_w, e_tgt_w, n_w, cur_w, jobs_w;
    logic [JB-1:0]    e_tgt_idx, in_idx;
    logic signed [LAG_W-1:0] e_lag;
    logic             in_oob, in_acc, edge_full;
    logic [JV_W-1:0]  n_clamp;
    logic [TB-1:0]    job_rel_q, job_dl_q, job_dur_q, cs_fwd, be_cs;
    logic signed [CW-1:0] c_be;
    logic             be_neg, topo_push;
    logic [ST_W-1:0]  run_st;

    assign e_src_w   = IW'(edge_q[SRC_LSB +: IDX_W]);
    assign e_tgt_w   = IW'(edge_q[TGT_LSB +: IDX_W]);
    assign e_tgt_idx = JB'(edge_q[TGT_LSB +: IDX_W]);
    assign e_lag     = $signed(edge_q[LAG_LSB +: LAG_W]);
    assign n_w       = IW'(r_n);
    assign cur_w     = IW'(r_cur);
    assign in_idx    = JB'(i_job_index);
    assign in_oob    = IW'(i_job_index) >= IW'(MAX_JOBS);
    assign in_acc    = i_cmd.accept && (i_cmd.op == DP_IDLE);
    assign edge_full = (r_edge_total == CNT_W'(MAX_EDGES));
    assign jobs_w    = IW'(r_jobs);

    always_comb begin
        if (r_jobs == '0) n_clamp = JV_W'(1);
        else if (jobs_w > IW'(MAX_JOBS)) n_clamp = JV_W'(MAX_JOBS);
        else n_clamp = JV_W'(jobs_w);
    end

    assign job_rel_q = job_q[2*TB +: TB];
    assign job_dl_q  = job_q[TB +: TB];
    assign job_dur_q = job_q[0 +: TB];

    assign cs_fwd = sat_c($signed(CW'(r_val)) + CW'(e_lag));
    assign c_be   = $signed(CW'(fin_q)) - $signed(CW'(job_dur_q))
                  + $signed(CW'(r_dur)) - CW'(r_lag);
    assign be_neg = (c_be < 0);
    assign be_cs  = sat_c(c_be);

    // the order queue never holds more than MAX_JOBS entries
    assign topo_push = (pend_q == CNT_W'(1)) && (r_tail < JV_W'(MAX_JOBS));

    always_comb begin
        if (r_ovf) run_st = ST_OVF;
        else if (r_tail != r_n) run_st = ST_CYCLE;
        else if (r_infeas) run_st = ST_INFEAS;
        else run_st = ST_OK;
    end

    assign o_stat.k_end     = (r_k == r_edge_total);
    assign o_stat.v_last    = ((r_v + JV_W'(1)) == r_n);
    assign o_stat.v_zero    = (r_v == '0);
    assign o_stat.q_empty   = (r_head == r_tail);
    assign o_stat.topo_full = (r_tail == r_n);
    assign o_stat.hit_in    = (e_src_w < n_w) && (e_tgt_w < n_w);
    assign o_stat.hit_src   = (e_src_w == cur_w) && (e_tgt_w < n_w);
    assign o_stat.out_free  = !r_ov || i_out_ready;

    // memory address and write selection
    always_comb begin
        job_we   = in_acc && (t_in_op'(i_operation) == IN_LOAD) && !in_oob;
        job_wa   = in_idx;
        job_wd   = {sat_in(i_release_time), sat_in(i_deadline_time),
                    sat_in(i_job_duration)};
        edge_we  = in_acc && (t_in_op'(i_operation) == IN_EDGE) && !edge_full;
        edge_wa  = r_edge_total[EB-1:0];
        edge_wd  = {i_edge_lag, i_edge_target, i_edge_source};
        edge_ra  = r_k[EB-1:0];
        start_we = 1'b0;
        start_wa = r_v[JB-1:0];
        start_wd = job_rel_q;
        fin_we   = 1'b0;
        fin_wa   = r_v[JB-1:0];
        fin_wd   = job_dl_q;
        pend_we  = 1'b0;
        pend_wa  = r_v[JB-1:0];
        pend_wd  = '0;
        topo_we  = 1'b0;
        topo_wa  = r_tail[JB-1:0];
        topo_wd  = r_v[JB-1:0];
        job_ra   = r_v[JB-1:0];
        start_ra = r_idx;
        fin_ra   = r_idx;
        pend_ra  = r_v[JB-1:0];
        topo_ra  = r_v[JB-1:0];
        unique case (i_cmd.op)
            DP_INIT_WR: begin
                start_we = 1'b1;
                fin_we   = 1'b1;
                pend_we  = 1'b1;
            end
            DP_CNT_CHK, DP_KE_CHK: pend_ra = e_tgt_idx;
            DP_CNT_WR: begin
                pend_we = 1'b1;
                pend_wa = r_tgt;
                pend_wd = pend_q + CNT_W'(1);
            end
            DP_SEED_WR: topo_we = (pend_q == '0);
            DP_KHD_RD:  topo_ra = r_head[JB-1:0];
            DP_KE_WR: begin
                pend_we = 1'b1;
                pend_wa = r_tgt;
                pend_wd = pend_q - CNT_W'(1);
                topo_we = topo_push;
                topo_wd = r_tgt;
            end
            DP_FWD_SRD: start_ra = topo_q;
            DP_FE_CHK:  start_ra = e_tgt_idx;
            DP_FE_WR: begin
                start_we = (r_cs > start_q);
                start_wa = r_tgt;
                start_wd = r_cs;
            end
            DP_BWD_VRD: begin
                fin_ra = topo_q;
                job_ra = topo_q;
            end
            DP_BE_CHK: begin
                fin_ra = e_tgt_idx;
                job_ra = e_tgt_idx;
            end
            DP_BWD_WB: begin
                fin_we = 1'b1;
                fin_wa = r_cur;
                fin_wd = r_val;
            end
            default: begin
            end
        endcase
    end

    cptw_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS)) u_job_ram (
        .i_clk(i_clk), .i_we(job_we), .i_waddr(job_wa), .i_wdata(job_wd),
        .i_raddr(job_ra), .o_rdata(job_q)
    );
    cptw_ram #(.WIDTH(TB), .DEPTH(MAX_JOBS)) u_start_ram (
        .i_clk(i_clk), .i_we(start_we), .i_waddr(start_wa), .i_wdata(start_wd),
        .i_raddr(start_ra), .o_rdata(start_q)
    );
    cptw_ram #(.WIDTH(TB), .DEPTH(MAX_JOBS)) u_finish_ram (
        .i_clk(i_clk), .i_we(fin_we), .i_waddr(fin_wa), .i_wdata(fin_wd),
        .i_raddr(fin_ra), .o_rdata(fin_q)
    );
    cptw_ram #(.WIDTH(CNT_W), .DEPTH(MAX_JOBS)) u_pend_ram (
        .i_clk(i_clk), .i_we(pend_we), .i_waddr(pend_wa), .i_wdata(pend_wd),
        .i_raddr(pend_ra), .o_rdata(pend_q)
    );
    cptw_ram #(.WIDTH(JB), .DEPTH(MAX_JOBS)) u_topo_ram (
        .i_clk(i_clk), .i_we(topo_we), .i_waddr(topo_wa), .i_wdata(topo_wd),
        .i_raddr(topo_ra), .o_rdata(topo_q)
    );
    cptw_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_wa), .i_wdata(edge_wd),
        .i_raddr(edge_ra), .o_rdata(edge_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_total <= '0;
            r_ovf        <= 1'b0;
            r_run_status <= ST_OK;
            r_jobs       <= JOBS_RESET;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_jobs <= i_cfg_wr_data;
            if (in_acc && (t_in_op'(i_operation) == IN_EDGE)) begin
                if (edge_full) r_ovf <= 1'b1;
                else r_edge_total <= r_edge_total + CNT_W'(1);
            end
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            if ((i_cmd.op == DP_RD_B) && o_stat.out_free) r_ov <= 1'b1;
            if ((i_cmd.op == DP_DONE) && o_stat.out_free) begin
                r_ov         <= 1'b1;
                r_run_status <= run_st;
                r_edge_total <= '0;
                r_ovf        <= 1'b0;
            end
        end
    end

    // run counters and payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_IDLE: begin
                if (in_acc) begin
                    r_idx    <= in_idx;
                    r_oob    <= in_oob;
                    r_n      <= n_clamp;
                    r_v      <= '0;
                    r_head   <= '0;
                    r_tail   <= '0;
                    r_infeas <= 1'b0;
                end
            end
            DP_RD_B: begin
                if (o_stat.out_free) begin
                    r_out_status <= r_run_status;
                    r_out_es     <= r_oob ? '0 : FT_W'(start_q);
                    r_out_lf     <= r_oob ? '0 : FT_W'(fin_q);
                end
            end
            DP_INIT_WR: begin
                r_v <= o_stat.v_last ? '0 : r_v + JV_W'(1);
                r_k <= '0;
            end
            DP_CNT_CHK, DP_KE_CHK: begin
                r_tgt <= e_tgt_idx;
                if (!((i_cmd.op == DP_CNT_CHK) ? o_stat.hit_in : o_stat.hit_src)) begin
                    r_k <= r_k + CNT_W'(1);
                end
            end
            DP_CNT_WR: r_k <= r_k + CNT_W'(1);
            DP_SEED_WR: begin
                r_v <= o_stat.v_last ? '0 : r_v + JV_W'(1);
                if (pend_q == '0) r_tail <= r_tail + JV_W'(1);
            end
            DP_KHD_V: begin
                r_cur  <= topo_q;
                r_head <= r_head + JV_W'(1);
                r_k    <= '0;
            end
            DP_KE_WR: begin
                r_k <= r_k + CNT_W'(1);
                if (topo_push) r_tail <= r_tail + JV_W'(1);
            end
            DP_FWD_SRD, DP_BWD_VRD: r_cur <= topo_q;
            DP_FWD_SV: begin
                r_val <= start_q;
                r_k   <= '0;
            end
            DP_FE_RD: begin
                if (o_stat.k_end) begin
                    r_v <= o_stat.v_last ? r_n - JV_W'(1) : r_v + JV_W'(1);
                end
            end
            DP_FE_CHK: begin
                r_tgt <= e_tgt_idx;
                r_cs  <= cs_fwd;
                if (!o_stat.hit_src) r_k <= r_k + CNT_W'(1);
            end
            DP_FE_WR: r_k <= r_k + CNT_W'(1);
            DP_BWD_V: begin
                r_val <= fin_q;
                r_dur <= job_dur_q;
                r_k   <= '0;
            end
            DP_BE_CHK: begin
                r_lag <= e_lag;
                if (!o_stat.hit_src) r_k <= r_k + CNT_W'(1);
            end
            DP_BE_CALC: begin
                if (be_neg) r_infeas <= 1'b1;
                if (be_cs < r_val) r_val <= be_cs;
                r_k <= r_k + CNT_W'(1);
            end
            DP_BWD_WB: begin
                if (!o_stat.v_zero) r_v <= r_v - JV_W'(1);
            end
            DP_DONE: begin
                if (o_stat.out_free) begin
                    r_out_status <= run_st;
                    r_out_es     <= '0;
                    r_out_lf     <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid      = r_ov;
    assign o_status         = r_out_status;
    assign o_earliest_start = r_out_es;
    assign o_latest_finish  = r_out_lf;

endmodule

FILE: tb/sv/critical_path_time_windows_checker.sv
// cptw_window_checker: watches the config port and both channels of the time window unit,
// predicts each result and compares it field by field; depends on cptw_pkg
`timescale 1ns / 100ps

module cptw_window_checker import cptw_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_W-1:0]        i_cfg_wr_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [IDX_W-1:0]        i_job_index,
    input  logic [FT_W-1:0]         i_release_time,
    input  logic [FT_W-1:0]         i_deadline_time,
    input  logic [FT_W-1:0]         i_job_duration,
    input  logic [IDX_W-1:0]        i_edge_source,
    input  logic [IDX_W-1:0]        i_edge_target,
    input  logic signed [LAG_W-1:0] i_edge_lag,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [ST_W-1:0]         i_status,
    input  logic [FT_W-1:0]         i_earliest_start,
    input  logic [FT_W-1:0]         i_latest_finish,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int JOB_SLOTS  = 256;
    localparam int EDGE_SLOTS = 1024;
    localparam longint TIME_TOP = 65535;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [FT_W-1:0] start;
        logic [FT_W-1:0] finish;
    } window_t;

    window_t window_q[$];

    logic [FT_W-1:0]         release_mem[JOB_SLOTS];
    logic [FT_W-1:0]         deadline_mem[JOB_SLOTS];
    logic [FT_W-1:0]         duration_mem[JOB_SLOTS];
    logic [FT_W-1:0]         start_mem[JOB_SLOTS];
    logic [FT_W-1:0]         finish_mem[JOB_SLOTS];
    logic [IDX_W-1:0]        edge_src[EDGE_SLOTS];
    logic [IDX_W-1:0]        edge_tgt[EDGE_SLOTS];
    logic signed [LAG_W-1:0] edge_lag[EDGE_SLOTS];
    int                      edge_cnt = 0;
    logic                    ovf_seen = 1'b0;
    logic [ST_W-1:0]         last_status = ST_OK;
    logic [CFG_W-1:0]        jobs_cfg = JOBS_RESET;
    int                      fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // forward and backward pass over a topological order, as the unit computes it
    function automatic logic [ST_W-1:0] schedule_windows();
        int              n;
        int              head;
        int              tail;
        int              v;
        int              k;
        int              t;
        int              pend[JOB_SLOTS];
        int              order[JOB_SLOTS];
        longint          c;
        logic            infeas;
        logic [ST_W-1:0] st;
        n = (jobs_cfg == 0) ? 1 : ((jobs_cfg > JOB_SLOTS) ? JOB_SLOTS : int'(jobs_cfg));
        head   = 0;
        tail   = 0;
        infeas = 1'b0;
        for (v = 0; v < n; v++) begin
            start_mem[v]  = release_mem[v];
            finish_mem[v] = deadline_mem[v];
            pend[v]       = 0;
        end
        for (k = 0; k < edge_cnt; k++)
            if (edge_src[k] < n && edge_tgt[k] < n) pend[edge_tgt[k]]++;
        for (v = 0; v < n; v++)
            if (pend[v] == 0) order[tail++] = v;
        while (head < tail) begin
            v = order[head++];
            for (k = 0; k < edge_cnt; k++) begin
                if (edge_src[k] == v && edge_tgt[k] < n) begin
                    t = edge_tgt[k];
                    pend[t]--;
                    if (pend[t] == 0 && tail < JOB_SLOTS) order[tail++] = t;
                end
            end
        end
        if (tail == n) begin
            for (int i = 0; i < n; i++) begin
                v = order[i];
                for (k = 0; k < edge_cnt; k++) begin
                    if (edge_src[k] == v && edge_tgt[k] < n) begin
                        t = edge_tgt[k];
                        c = longint'(start_mem[v]) + longint'(edge_lag[k]);
                        if (c < 0) c = 0;
                        if (c > TIME_TOP) c = TIME_TOP;
                        if (c > longint'(start_mem[t])) start_mem[t] = c[FT_W-1:0];
                    end
                end
            end
            for (int i = n; i > 0; i--) begin
                v = order[i-1];
                for (k = 0; k < edge_cnt; k++) begin
                    if (edge_src[k] == v && edge_tgt[k] < n) begin
                        t = edge_tgt[k];
                        c = longint'(finish_mem[t]) - longint'(duration_mem[t])
                          + longint'(duration_mem[v]) - longint'(edge_lag[k]);
                        if (c < 0) begin
                            infeas = 1'b1;
                            c = 0;
                        end
                        if (c > TIME_TOP) c = TIME_TOP;
                        if (c < longint'(finish_mem[v])) finish_mem[v] = c[FT_W-1:0];
                    end
                end
            end
        end
        if (ovf_seen) st = ST_OVF;
        else if (tail != n) st = ST_CYCLE;
        else if (infeas) st = ST_INFEAS;
        else st = ST_OK;
        last_status = st;
        edge_cnt    = 0;
        ovf_seen    = 1'b0;
        return st;
    endfunction

    always @(posedge i_clk) begin
        window_t got;
        window_t want;
        if (!i_rst_n) begin
            edge_cnt    = 0;
            ovf_seen    = 1'b0;
            last_status = ST_OK;
            jobs_cfg    = JOBS_RESET;
            window_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_status, i_earliest_start, i_latest_finish};
                if (window_q.size() == 0) begin
                    $error("unexpected result: status %0d start %0d finish %0d",
                           got.status, got.start, got.finish);
                    fails++;
                end else begin
                    want = window_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.start !== want.start) begin
                        $error("earliest_start: expected %0d, got %0d", want.start, got.start);
                        fails++;
                    end
                    if (got.finish !== want.finish) begin
                        $error("latest_finish: expected %0d, got %0d", want.finish, got.finish);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (t_in_op'(i_operation))
                    IN_LOAD: begin
                        release_mem[i_job_index]  = i_release_time;
                        deadline_mem[i_job_index] = i_deadline_time;
                        duration_mem[i_job_index] = i_job_duration;
                    end
                    IN_EDGE: begin
                        if (edge_cnt < EDGE_SLOTS) begin
                            edge_src[edge_cnt] = i_edge_source;
                            edge_tgt[edge_cnt] = i_edge_target;
                            edge_lag[edge_cnt] = i_edge_lag;
                            edge_cnt++;
                        end else begin
                            ovf_seen = 1'b1;
                        end
                    end
                    IN_RUN: begin
                        want = '{schedule_windows(), '0, '0};
                        window_q.push_back(want);
                    end
                    default: begin
                        want = '{last_status, start_mem[i_job_index], finish_mem[i_job_index]};
                        window_q.push_back(want);
                    end
                endcase
            end
            if (i_cfg_wr_en) jobs_cfg = i_cfg_wr_data;
        end
        o_pending    <= window_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/sv/critical_path_time_windows_unit_tb.sv
// critical_path_time_windows_unit_tb: drives job loads, lag edges, runs and reads into the unit
// under random stalls outside calm phases; checked by cptw_window_checker; depends on cptw_pkg
`timescale 1ns / 100ps

module critical_path_time_windows_unit_tb;
    import cptw_pkg::*;

    localparam int STALL_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 700;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]        cfg_wr_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [OP_W-1:0]         operation = '0;
    logic [IDX_W-1:0]        job_index = '0;
    logic [FT_W-1:0]         release_time = '0;
    logic [FT_W-1:0]         deadline_time = '0;
    logic [FT_W-1:0]         job_duration = '0;
    logic [IDX_W-1:0]        edge_source = '0;
    logic [IDX_W-1:0]        edge_target = '0;
    logic signed [LAG_W-1:0] edge_lag = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [ST_W-1:0]         status;
    logic [FT_W-1:0]         earliest_start;
    logic [FT_W-1:0]         latest_finish;
    int                      fail_count;
    int                      pending;

    logic calm = 1'b0;
    int   txn_count = 0;
    int   run_count = 0;
    int   read_count = 0;
    int   cur_jobs = 256;
    int   max_written = 0;
    int   stall_cnt = 0;

    critical_path_time_windows_unit u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_operation      (operation),
        .i_job_index      (job_index),
        .i_release_time   (release_time),
        .i_deadline_time  (deadline_time),
        .i_job_duration   (job_duration),
        .i_edge_source    (edge_source),
        .i_edge_target    (edge_target),
        .i_edge_lag       (edge_lag),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (status),
        .o_earliest_start (earliest_start),
        .o_latest_finish  (latest_finish)
    );

    cptw_window_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_operation      (operation),
        .i_job_index      (job_index),
        .i_release_time   (release_time),
        .i_deadline_time  (deadline_time),
        .i_job_duration   (job_duration),
        .i_edge_source    (edge_source),
        .i_edge_target    (edge_target),
        .i_edge_lag       (edge_lag),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_status         (status),
        .i_earliest_start (earliest_start),
        .i_latest_finish  (latest_finish),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 27);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // small values half the time so windows stay meaningful, otherwise zero, all ones or the full range
    function automatic logic [FT_W-1:0] pick_time();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom;
            default: return $urandom_range(0, 400);
        endcase
    endfunction

    task automatic send_txn(input t_in_op op, input logic [IDX_W-1:0] idx,
                            input logic [FT_W-1:0] rel, input logic [FT_W-1:0] dl,
                            input logic [FT_W-1:0] dur, input logic [IDX_W-1:0] src,
                            input logic [IDX_W-1:0] tgt, input logic [LAG_W-1:0] lag);
        if (!calm) begin
            while ($urandom_range(99) < 27) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid      <= 1'b1;
        operation     <= op;
        job_index     <= idx;
        release_time  <= rel;
        deadline_time <= dl;
        job_duration  <= dur;
        edge_source   <= src;
        edge_target   <= tgt;
        edge_lag      <= lag;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        txn_count++;
    endtask

    task automatic load_job(input int idx);
        send_txn(IN_LOAD, idx, pick_time(), pick_time(), pick_time(), $urandom, $urandom,
                 $urandom);
    endtask

    task automatic add_edge(input int src, input int tgt, input logic [LAG_W-1:0] lag);
        send_txn(IN_EDGE, $urandom, $urandom, $urandom, $urandom, src, tgt, lag);
    endtask

    task automatic start_run();
        send_txn(IN_RUN, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        run_count++;
        if (cur_jobs > max_written) max_written = cur_jobs;
    endtask

    task automatic read_job(input int idx);
        send_txn(IN_READ, idx, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        read_count++;
    endtask

    // holds the sender until every expected result is back, plus margin for edge writes
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_jobs(input int value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_jobs = (value == 0) ? 1 : ((value > 256) ? 256 : value);
    endtask

    // one well-formed job set: reloads, edges, run, reads; noise mixed in
    task automatic job_phase(input int cfg_value, input int n_edges, input bit cyclic);
        int a;
        int b;
        set_jobs(cfg_value);
        repeat ($urandom_range(0, 4)) load_job($urandom_range(0, cur_jobs - 1));
        for (int e = 0; e < n_edges; e++) begin
            case ($urandom_range(19))
                0: load_job($urandom_range(0, 255));
                1: add_edge($urandom_range(0, 255), $urandom_range(cur_jobs, 255), $urandom);
                2: if (max_written > 0) read_job($urandom_range(0, max_written - 1));
                default: begin
                    a = $urandom_range(0, cur_jobs - 1);
                    b = $urandom_range(0, cur_jobs - 1);
                    if (!cyclic) begin
                        if (cur_jobs == 1) b = $urandom_range(1, 255);
                        else begin
                            while (a == b) b = $urandom_range(0, cur_jobs - 1);
                            if (a > b) begin
                                a = a ^ b;
                                b = a ^ b;
                                a = a ^ b;
                            end
                        end
                    end
                    add_edge(a, b, $urandom);
                end
            endcase
        end
        if ($urandom_range(3) == 0) drain();
        start_run();
        repeat ($urandom_range(1, 5)) read_job($urandom_range(0, cur_jobs - 1));
    endtask

    initial begin
        int random_start;
        int n_edges;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every job gets data so no run ever touches an unloaded entry
        for (int j = 0; j < 256; j++) load_job(j);

        // extremes, lag saturation, ignored edge, then a self-loop
        set_jobs(4);
        send_txn(IN_LOAD, 0, 16'd0, 16'hffff, 16'd0, 0, 0, 0);
        send_txn(IN_LOAD, 1, 16'hffff, 16'd0, 16'hffff, 0, 0, 0);
        send_txn(IN_LOAD, 2, 16'd100, 16'd5000, 16'd30, 0, 0, 0);
        send_txn(IN_LOAD, 3, 16'd7, 16'hffff, 16'hffff, 0, 0, 0);
        add_edge(0, 1, 16'h7fff);
        add_edge(0, 2, 16'h8000);
        add_edge(1, 3, 16'h7fff);
        add_edge(2, 3, 16'd5);
        add_edge(3, 200, 16'd0);
        start_run();
        for (int j = 0; j < 4; j++) read_job(j);
        add_edge(2, 2, 16'd1);
        start_run();
        read_job(2);
        send_txn(IN_LOAD, 255, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0);

        // full job range, read back the top job and job 0
        set_jobs(256);
        add_edge(254, 255, 16'd3);
        add_edge(0, 255, 16'hfff0);
        start_run();
        read_job(255);
        read_job(0);

        // edge store overflow on a single job
        set_jobs(1);
        for (int e = 0; e < 1026; e++) add_edge($urandom_range(0, 255), $urandom_range(0, 255),
                                                 $urandom);
        start_run();
        read_job(0);

        job_phase(0, 3, 1'b0);
        job_phase(511, 4, 1'b0);
        job_phase(300, 2, 1'b1);

        random_start = txn_count;
        calm = 1'b1;
        for (int p = 0; p < 6; p++) job_phase($urandom_range(2, 12), $urandom_range(3, 16), 1'b0);
        calm = 1'b0;
        while (txn_count - random_start < RANDOM_ITEMS) begin
            n_edges = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 16);
            job_phase(($urandom_range(19) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12),
                      n_edges, $urandom_range(99) < 15);
        end

        drain();
        repeat (30) @(posedge clk);
        $display("covered %0d transactions: %0d runs, %0d reads, job counts 0 to 511,",
                 txn_count, run_count, read_count);
        $display("acyclic and cyclic lag graphs, infeasible windows and edge store overflow");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: critical_path_time_windows_unit.f
hw/rtl/cptw_pkg.sv
hw/rtl/cptw_ram.sv
hw/rtl/cptw_ctrl.sv
hw/rtl/cptw_dp.sv
hw/rtl/critical_path_time_windows_unit.sv
tb/sv/critical_path_time_windows_checker.sv
tb/sv/critical_path_time_windows_unit_tb.sv
